### src/ismc_pkg.sv
package ismc_pkg;

  // Fixed field widths of the update interface
  localparam int COORD_W   = 7;
  localparam int RND_W     = 16;
  localparam int FIELD_W   = 12;
  localparam int MAG_W     = 16;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_B    = 2'd0,
    CFG_TABLE_LOW  = 2'd1,
    CFG_TABLE_MID  = 2'd2,
    CFG_TABLE_HIGH = 2'd3
  } cfg_idx_t;

  // Acceptance threshold table, ten 16-bit entries in three registers
  typedef struct packed {
    logic [31:0] high;
    logic [63:0] mid;
    logic [63:0] low;
  } thr_tab_t;

  // One lattice word: spin (1 = +1) and the visit mark of the site
  typedef struct packed {
    logic spin;
    logic visit;
  } site_word_t;

endpackage

### src/ismc_lattice_ram.sv
module ismc_lattice_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        wr_addr,
  input  ismc_pkg::site_word_t wr_data,
  input  logic [AW-1:0]        rd_addr,
  output ismc_pkg::site_word_t rd_data
);
  import ismc_pkg::*;

  site_word_t mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/ismc_decide.sv
module ismc_decide (
  input  logic                                spin_pos,
  input  logic [2:0]                          nb_pos,
  input  logic signed [ismc_pkg::FIELD_W-1:0] field_b,
  input  ismc_pkg::thr_tab_t                  thr_tab,
  input  logic [ismc_pkg::RND_W-1:0]          accept_random,
  output logic                                flip
);
  import ismc_pkg::*;

  logic signed [FIELD_W:0] n_scaled;
  logic signed [FIELD_W:0] b_ext;
  logic                    de_neg;
  logic [3:0]              idx;
  logic [THR_W-1:0]        thr;

  // 256*n with n = 2*nb_pos - 4, so 512*nb_pos - 1024
  assign n_scaled = $signed({1'b0, nb_pos, 9'b0}) - $signed((FIELD_W+1)'(1024));
  assign b_ext    = {field_b[FIELD_W-1], field_b};

  // Sign of dE = 2*s*(256n - b)
  assign de_neg = spin_pos ? (n_scaled < b_ext) : (n_scaled > b_ext);

  // Table entry: 5 for a +1 spin, plus (n+4)/2 which is nb_pos
  assign idx = spin_pos ? (4'd5 + {1'b0, nb_pos}) : {1'b0, nb_pos};

  always_comb begin
    case (idx)
      4'd0:    thr = thr_tab.low[15:0];
      4'd1:    thr = thr_tab.low[31:16];
      4'd2:    thr = thr_tab.low[47:32];
      4'd3:    thr = thr_tab.low[63:48];
      4'd4:    thr = thr_tab.mid[15:0];
      4'd5:    thr = thr_tab.mid[31:16];
      4'd6:    thr = thr_tab.mid[47:32];
      4'd7:    thr = thr_tab.mid[63:48];
      4'd8:    thr = thr_tab.high[15:0];
      4'd9:    thr = thr_tab.high[31:16];
      default: thr = '0;
    endcase
  end

  assign flip = de_neg || (accept_random < thr);

endmodule

### src/ising_metropolis_site_update.sv
// Site update: start leads through the row and column steps, five lattice reads,
// one read tail and decide to the result strobe; the row or column step repeats
// for each subtraction while row >= ROWS or col >= COLS (none at 128 x 128); busy
// drops when the result shows, so the next start may come in that cycle and no sooner.
// Reinit runs a clearing pass over the lattice RAM and then gives a result. Reset
// (synchronous, active high) runs the same pass, busy, no result; receiver cannot stall.
module ising_metropolis_site_update #(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [ismc_pkg::COORD_W-1:0]        row,
  input  logic [ismc_pkg::COORD_W-1:0]        col,
  input  logic [ismc_pkg::RND_W-1:0]          accept_random,
  output logic                                result_valid,
  output logic                                new_spin,
  output logic                                flipped,
  output logic signed [ismc_pkg::MAG_W-1:0]   magnetization,
  output logic                                sweep_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ismc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ismc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ismc_pkg::*;

  localparam int SITES = ROWS * COLS;
  localparam int AW    = $clog2(SITES);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int RWW   = (RW > COORD_W) ? RW : COORD_W;
  localparam int CWW   = (CW > COORD_W) ? CW : COORD_W;
  localparam int VCW   = $clog2(SITES + 1);
  localparam int TW    = ($clog2(SITES) + 2 > MAG_W) ? $clog2(SITES) + 2 : MAG_W;
  localparam logic signed [TW-1:0] TOTAL_INIT = TW'(-SITES);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_MOD_ROW, S_MOD_COL, S_READ, S_TAIL, S_DECIDE
  } state_t;

  typedef enum logic [2:0] {
    NB_SITE, NB_UP, NB_DOWN, NB_RIGHT, NB_LEFT
  } nb_t;

  state_t                   state;
  nb_t                      step;
  nb_t                      cap_sel;
  logic                     cap_vld;
  logic [RWW-1:0]           rr;
  logic [CWW-1:0]           cc;
  logic [RND_W-1:0]         rnd_q;
  site_word_t               site_q;
  logic [2:0]               kcnt;
  logic [AW-1:0]            clr_addr;
  logic                     clr_reinit;
  logic                     vpar;
  logic [VCW-1:0]           vcount;
  logic signed [TW-1:0]     total;

  logic signed [FIELD_W-1:0] field_b;
  thr_tab_t                  thr_tab;

  logic [RW-1:0]   rs, r_up, r_dn, sel_r;
  logic [CW-1:0]   cs, c_rt, c_lf, sel_c;
  logic [AW-1:0]   addr;
  logic            ram_we;
  logic [AW-1:0]   ram_wr_addr;
  site_word_t      ram_wr_data;
  site_word_t      ram_rd_data;
  logic            flip;
  logic            spin_next;
  logic            was_visited;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_b <= '0;
      thr_tab <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIELD_B:    field_b      <= cfg_data[FIELD_W-1:0];
        CFG_TABLE_LOW:  thr_tab.low  <= cfg_data;
        CFG_TABLE_MID:  thr_tab.mid  <= cfg_data;
        CFG_TABLE_HIGH: thr_tab.high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Wrapped neighbor coordinates and the lattice address
  always_comb begin
    rs    = rr[RW-1:0];
    cs    = cc[CW-1:0];
    r_up  = (rs == '0) ? RW'(ROWS - 1) : rs - RW'(1);
    r_dn  = (rs == RW'(ROWS - 1)) ? '0 : rs + RW'(1);
    c_lf  = (cs == '0) ? CW'(COLS - 1) : cs - CW'(1);
    c_rt  = (cs == CW'(COLS - 1)) ? '0 : cs + CW'(1);
    sel_r = rs;
    sel_c = cs;
    if (state == S_READ) begin
      case (step)
        NB_UP:    sel_r = r_up;
        NB_DOWN:  sel_r = r_dn;
        NB_RIGHT: sel_c = c_rt;
        NB_LEFT:  sel_c = c_lf;
        default: ;
      endcase
    end
    addr = AW'(sel_r) * AW'(COLS) + AW'(sel_c);
  end

  // Flip decision for the site held in site_q
  ismc_decide u_decide (
    .spin_pos      (site_q.spin),
    .nb_pos        (kcnt),
    .field_b       (field_b),
    .thr_tab       (thr_tab),
    .accept_random (rnd_q),
    .flip          (flip)
  );

  assign spin_next   = site_q.spin ^ flip;
  assign was_visited = (site_q.visit == vpar);

  // Lattice write port: clearing pass or site write-back
  always_comb begin
    ram_we            = (state == S_CLEAR) || (state == S_DECIDE);
    ram_wr_addr       = (state == S_CLEAR) ? clr_addr : addr;
    ram_wr_data.spin  = (state == S_CLEAR) ? 1'b0 : spin_next;
    ram_wr_data.visit = (state == S_CLEAR) ? ~vpar : vpar;
  end

  ismc_lattice_ram #(
    .DEPTH (SITES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      step         <= NB_SITE;
      cap_sel      <= NB_SITE;
      cap_vld      <= 1'b0;
      clr_addr     <= '0;
      clr_reinit   <= 1'b0;
      vpar         <= 1'b0;
      vcount       <= '0;
      total        <= TOTAL_INIT;
      result_valid <= 1'b0;
      kcnt         <= '0;
    end else begin
      result_valid <= 1'b0;

      // Collect read data in the cycle after each address
      if (cap_vld) begin
        if (cap_sel == NB_SITE) begin
          site_q <= ram_rd_data;
        end else begin
          kcnt <= kcnt + {2'b0, ram_rd_data.spin};
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            rr    <= RWW'(row);
            cc    <= CWW'(col);
            rnd_q <= accept_random;
            if (func) begin
              clr_reinit <= 1'b1;
              clr_addr   <= '0;
              vcount     <= '0;
              total      <= TOTAL_INIT;
              state      <= S_CLEAR;
            end else begin
              state <= S_MOD_ROW;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SITES - 1)) begin
            state      <= S_IDLE;
            clr_reinit <= 1'b0;
            if (clr_reinit) begin
              result_valid  <= 1'b1;
              new_spin      <= 1'b0;
              flipped       <= 1'b0;
              sweep_done    <= 1'b0;
              magnetization <= total[MAG_W-1:0];
            end
          end
        end
        S_MOD_ROW: begin
          if ({1'b0, rr} >= (RWW+1)'(ROWS)) begin
            rr <= rr - RWW'(ROWS);
          end else begin
            state <= S_MOD_COL;
          end
        end
        S_MOD_COL: begin
          if ({1'b0, cc} >= (CWW+1)'(COLS)) begin
            cc <= cc - CWW'(COLS);
          end else begin
            state <= S_READ;
            step  <= NB_SITE;
            kcnt  <= '0;
          end
        end
        S_READ: begin
          cap_vld <= 1'b1;
          cap_sel <= step;
          case (step)
            NB_SITE:  step <= NB_UP;
            NB_UP:    step <= NB_DOWN;
            NB_DOWN:  step <= NB_RIGHT;
            NB_RIGHT: step <= NB_LEFT;
            default: begin
              step  <= NB_SITE;
              state <= S_TAIL;
            end
          endcase
        end
        S_TAIL: begin
          cap_vld <= 1'b0;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          state        <= S_IDLE;
          result_valid <= 1'b1;
          new_spin     <= spin_next;
          flipped      <= flip;
          sweep_done   <= 1'b0;
          if (flip) begin
            total         <= site_q.spin ? total - TW'(2) : total + TW'(2);
            magnetization <= site_q.spin ? MAG_W'(total - TW'(2))
                                         : MAG_W'(total + TW'(2));
          end else begin
            magnetization <= total[MAG_W-1:0];
          end
          // Mark the visit; a full sweep flips the mark polarity
          if (!was_visited) begin
            if (vcount == VCW'(SITES - 1)) begin
              sweep_done <= 1'b1;
              vcount     <= '0;
              vpar       <= ~vpar;
            end else begin
              vcount <= vcount + VCW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/ising_metropolis_site_update_test.sv
`timescale 1ns / 100ps

module ising_metropolis_site_update_test;
  import ismc_pkg::*;

  localparam int N_ROWS = 128;
  localparam int N_COLS = 128;
  localparam int N_SITES = N_ROWS * N_COLS;
  localparam int PLAN_LEN = 21;

  localparam logic FN_UPDATE = 1'b0;
  localparam logic FN_REINIT = 1'b1;

  typedef struct packed {
    logic spin;
    logic flip;
    logic signed [MAG_W-1:0] mag;
    logic done;
  } site_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} plan_kind_t;

  typedef struct {
    plan_kind_t kind;
    logic f;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [RND_W-1:0] rnd;
    cfg_idx_t idx;
    logic [CFG_DATA_W-1:0] data;
    bit typed;
    site_result_t want;
  } plan_row_t;

  // Lattice right after reset or reinit, and after the first flip of it
  localparam site_result_t ALL_DOWN = '{spin: 1'b0, flip: 1'b0, mag: -16'sd16384, done: 1'b0};
  localparam site_result_t FIRST_UP = '{spin: 1'b1, flip: 1'b1, mag: -16'sd16382, done: 1'b0};

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic func;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [RND_W-1:0] accept_random;
  logic result_valid;
  logic new_spin;
  logic flipped;
  logic signed [MAG_W-1:0] magnetization;
  logic sweep_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ising_metropolis_site_update #(
    .ROWS(N_ROWS),
    .COLS(N_COLS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .row(row),
    .col(col),
    .accept_random(accept_random),
    .result_valid(result_valid),
    .new_spin(new_spin),
    .flipped(flipped),
    .magnetization(magnetization),
    .sweep_done(sweep_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow lattice and registers
  bit lattice [N_ROWS][N_COLS];
  bit seen [N_ROWS][N_COLS];
  int seen_count;
  int mag_sum;
  logic signed [FIELD_W-1:0] field_b_q;
  logic [159:0] thr_bits;

  site_result_t pending_results [$];
  site_result_t oldest;
  plan_row_t plan [PLAN_LEN];
  int error_count;
  int idle_pct;
  logic [COORD_W-1:0] win_r;
  logic [COORD_W-1:0] win_c;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("ising_metropolis_site_update_test: errors");
    $finish;
  end

  function automatic void forget_visits();
    for (int i = 0; i < N_ROWS; i++)
      for (int j = 0; j < N_COLS; j++)
        seen[i][j] = 1'b0;
    seen_count = 0;
  endfunction

  function automatic void clear_lattice();
    for (int i = 0; i < N_ROWS; i++)
      for (int j = 0; j < N_COLS; j++)
        lattice[i][j] = 1'b0;
    forget_visits();
    mag_sum = -N_SITES;
  endfunction

  function automatic void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_FIELD_B: field_b_q = d[FIELD_W-1:0];
      CFG_TABLE_LOW: thr_bits[63:0] = d;
      CFG_TABLE_MID: thr_bits[127:64] = d;
      CFG_TABLE_HIGH: thr_bits[159:128] = d[31:0];
      default: ;
    endcase
  endfunction

  function automatic int spin_at(int r, int c);
    return lattice[r][c] ? 1 : -1;
  endfunction

  // Metropolis step on the shadow lattice
  function automatic site_result_t apply_metropolis(logic f, logic [COORD_W-1:0] r_in,
                                                    logic [COORD_W-1:0] c_in,
                                                    logic [RND_W-1:0] rnd);
    site_result_t res;
    int r, c, s, n, fb, de, idx;
    logic [THR_W-1:0] thr;
    res = '0;
    if (f == FN_REINIT) begin
      clear_lattice();
    end else begin
      r = int'(r_in) % N_ROWS;
      c = int'(c_in) % N_COLS;
      fb = int'(field_b_q);
      s = spin_at(r, c);
      n = spin_at((r + 1) % N_ROWS, c) + spin_at((r + N_ROWS - 1) % N_ROWS, c)
        + spin_at(r, (c + 1) % N_COLS) + spin_at(r, (c + N_COLS - 1) % N_COLS);
      de = 2 * s * (256 * n - fb);
      idx = (s > 0 ? 5 : 0) + (n + 4) / 2;
      thr = thr_bits[16*idx +: 16];
      if (de < 0 || rnd < thr) begin
        res.flip = 1'b1;
        lattice[r][c] = ~lattice[r][c];
        mag_sum += (s > 0) ? -2 : 2;
      end
      res.spin = lattice[r][c];
      // Mark the visit; the last new site closes the sweep
      if (!seen[r][c]) begin
        seen[r][c] = 1'b1;
        seen_count++;
        if (seen_count >= N_SITES) begin
          res.done = 1'b1;
          forget_visits();
        end
      end
    end
    res.mag = 16'(mag_sum);
    return res;
  endfunction

  function automatic plan_row_t mk_item(logic f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                        logic [RND_W-1:0] rnd, bit typed, site_result_t want);
    plan_row_t p;
    p.kind = ROW_ITEM;
    p.f = f;
    p.r = r;
    p.c = c;
    p.rnd = rnd;
    p.idx = CFG_FIELD_B;
    p.data = '0;
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t mk_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    plan_row_t p;
    p = mk_item(FN_UPDATE, '0, '0, '0, 1'b0, ALL_DOWN);
    p.kind = ROW_CFG;
    p.idx = idx;
    p.data = d;
    return p;
  endfunction

  // Drive one word at a falling edge and hold it until taken
  task automatic issue(logic f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                       logic [RND_W-1:0] rnd, bit typed, site_result_t want);
    site_result_t got;
    start <= 1'b1;
    func <= f;
    row <= r;
    col <= c;
    accept_random <= rnd;
    do @(posedge clk); while (busy);
    got = apply_metropolis(f, r, c, rnd);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // Hold off new words until every result has come back
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, d);
    @(negedge clk) cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_table();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Load all four registers; bits above each register are noise
  task automatic set_phase(logic signed [FIELD_W-1:0] fb, logic [63:0] lo, logic [63:0] mid,
                           logic [31:0] hi);
    logic [CFG_DATA_W-1:0] d;
    drain();
    d = {$urandom, $urandom};
    d[FIELD_W-1:0] = fb;
    write_reg(CFG_FIELD_B, d);
    write_reg(CFG_TABLE_LOW, lo);
    write_reg(CFG_TABLE_MID, mid);
    d = {$urandom, $urandom};
    d[31:0] = hi;
    write_reg(CFG_TABLE_HIGH, d);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 3))
      0: return FIELD_W'(int'($urandom_range(0, 2048)) - 1024);
      1: return FIELD_W'(256 * int'($urandom_range(0, 8)) - 1024);
      2: return -12'sd1024;
      default: return 12'sd1024;
    endcase
  endfunction

  // Mostly a small patch so neighbors interact, sometimes anywhere
  task automatic send_random();
    logic f;
    logic [COORD_W-1:0] r, c;
    f = ($urandom_range(0, 199) == 0) ? FN_REINIT : FN_UPDATE;
    if ($urandom_range(0, 3) != 0) begin
      r = win_r + COORD_W'($urandom_range(0, 5));
      c = win_c + COORD_W'($urandom_range(0, 5));
    end else begin
      r = COORD_W'($urandom_range(0, N_ROWS - 1));
      c = COORD_W'($urandom_range(0, N_COLS - 1));
    end
    maybe_pause();
    issue(f, r, c, RND_W'($urandom_range(0, 65535)), 1'b0, ALL_DOWN);
  endtask

  task automatic check_field(string what, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
      error_count++;
    end
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual spin %0d flip %0d mag %0d done %0d",
                 $time, new_spin, flipped, magnetization, sweep_done);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("new_spin", int'(oldest.spin), int'(new_spin));
        check_field("flipped", int'(oldest.flip), int'(flipped));
        check_field("magnetization", int'(oldest.mag), int'(magnetization));
        check_field("sweep_done", int'(oldest.done), int'(sweep_done));
      end
    end
  end

  initial begin
    error_count = 0;
    idle_pct = 20;
    rst = 1'b1;
    start = 1'b0;
    func = FN_UPDATE;
    row = '0;
    col = '0;
    accept_random = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FIELD_B;
    cfg_data = '0;
    clear_lattice();
    field_b_q = '0;
    thr_bits = '0;

    plan[0] = mk_item(FN_UPDATE, 7'd0, 7'd0, 16'h0000, 1'b1, ALL_DOWN);
    plan[1] = mk_item(FN_UPDATE, 7'd127, 7'd127, 16'hFFFF, 1'b1, ALL_DOWN);
    plan[2] = mk_cfg(CFG_FIELD_B, 64'hFFFF_FFFF_FFFF_FC00);
    // zero energy change with an all-zero table: no flip
    plan[3] = mk_item(FN_UPDATE, 7'd5, 7'd5, 16'h0000, 1'b1, ALL_DOWN);
    plan[4] = mk_cfg(CFG_TABLE_LOW, '1);
    plan[5] = mk_cfg(CFG_TABLE_MID, '1);
    plan[6] = mk_cfg(CFG_TABLE_HIGH, 64'h0000_0000_FFFF_FFFF);
    plan[7] = mk_item(FN_UPDATE, 7'd0, 7'd0, 16'h0000, 1'b1, FIRST_UP);
    plan[8] = mk_item(FN_UPDATE, 7'd0, 7'd1, 16'hFFFF, 1'b0, ALL_DOWN);
    // raise all four neighbors of (10,10)
    plan[9] = mk_item(FN_UPDATE, 7'd9, 7'd10, 16'h0000, 1'b0, ALL_DOWN);
    plan[10] = mk_item(FN_UPDATE, 7'd11, 7'd10, 16'h0000, 1'b0, ALL_DOWN);
    plan[11] = mk_item(FN_UPDATE, 7'd10, 7'd9, 16'h0000, 1'b0, ALL_DOWN);
    plan[12] = mk_item(FN_UPDATE, 7'd10, 7'd11, 16'h0000, 1'b0, ALL_DOWN);
    plan[13] = mk_cfg(CFG_FIELD_B, 64'h0000_0000_0000_0400);
    plan[14] = mk_item(FN_UPDATE, 7'd10, 7'd10, 16'hFFFF, 1'b0, ALL_DOWN);
    plan[15] = mk_cfg(CFG_FIELD_B, 64'h0);
    // negative energy change flips even at the top random value
    plan[16] = mk_item(FN_UPDATE, 7'd10, 7'd10, 16'hFFFF, 1'b0, ALL_DOWN);
    plan[17] = mk_item(FN_UPDATE, 7'd10, 7'd10, 16'hFFFF, 1'b0, ALL_DOWN);
    plan[18] = mk_item(FN_REINIT, 7'd127, 7'd127, 16'hFFFF, 1'b1, ALL_DOWN);
    plan[19] = mk_item(FN_UPDATE, 7'd127, 7'd0, 16'h7FFF, 1'b0, ALL_DOWN);
    plan[20] = mk_item(FN_UPDATE, 7'd0, 7'd127, 16'h8000, 1'b0, ALL_DOWN);

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed rows
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        maybe_pause();
        issue(plan[i].f, plan[i].r, plan[i].c, plan[i].rnd, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_phase(-12'sd1024, pick_table(), pick_table(), 32'(pick_table()));
        1: set_phase(12'sd1024, '0, '0, '0);
        2: set_phase(12'sd0, '1, '1, '1);
        default: set_phase(pick_field(), pick_table(), pick_table(), 32'(pick_table()));
      endcase
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 35);
      win_r = (p == 0) ? 7'd125 : COORD_W'($urandom_range(0, N_ROWS - 1));
      win_c = (p == 0) ? 7'd125 : COORD_W'($urandom_range(0, N_COLS - 1));
      repeat (185) send_random();
    end

    // Closing stretch, sender never idles
    set_phase(pick_field(), pick_table(), pick_table(), 32'(pick_table()));
    idle_pct = 0;
    win_r = COORD_W'($urandom_range(0, N_ROWS - 1));
    win_c = COORD_W'($urandom_range(0, N_COLS - 1));
    repeat (200) send_random();

    drain();
    repeat (30) @(posedge clk);
    if (error_count == 0)
      $display("ising_metropolis_site_update_test: clean");
    else
      $display("ising_metropolis_site_update_test: errors");
    $finish;
  end

endmodule

### files.f
src/ismc_pkg.sv
src/ismc_lattice_ram.sv
src/ismc_decide.sv
src/ising_metropolis_site_update.sv
tb/ising_metropolis_site_update_test.sv
